FILE: src/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// shared types, constants and register map of the pointer shake detector
// ----------------------------------------------------------------------------
package psd_pkg;

  // moving window of position deltas
  localparam int WINDOW_DEPTH = 8;
  localparam int HEAD_W       = $clog2(WINDOW_DEPTH);
  localparam int DELTA_W      = 17;
  localparam int SUM_W        = DELTA_W + $clog2(WINDOW_DEPTH);
  localparam int PROD_W       = 2 * SUM_W;
  localparam int DOT_W        = PROD_W + 1;

  // queue between front and back
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  // configuration port
  localparam int ADDR_W       = 5;
  localparam int DATA_W       = 32;
  localparam int REG_IDX_W    = 3;

  localparam logic [REG_IDX_W-1:0] REG_VIEW_LEFT       = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_VIEW_TOP        = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_VIEW_RIGHT      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_VIEW_BOTTOM     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COUNT_THRESHOLD = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_TIME_WINDOW     = 3'd5;

  localparam logic [7:0]  COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic        cmd;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
  } psd_in_t;

  typedef struct packed {
    logic       uturn;
    logic       shake;
    logic [7:0] shake_count;
  } psd_out_t;

  typedef struct packed {
    logic [15:0] view_left;
    logic [15:0] view_top;
    logic [15:0] view_right;
    logic [15:0] view_bottom;
    logic [7:0]  count_threshold;
    logic [15:0] time_window;
  } psd_cfg_t;

  // item kinds after classification
  typedef enum logic [1:0] {
    OP_MOVE,
    OP_TICK,
    OP_SKIP
  } psd_op_t;

  typedef struct packed {
    psd_op_t     op;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
  } psd_qitem_t;

  // queue status seen by the two sides
  typedef struct packed {
    logic full;
    logic valid;
  } psd_qstat_t;

endpackage

FILE: src/psd_front.sv
// ----------------------------------------------------------------------------
// psd_front
// accepts input items and classifies them as tick, move inside view or skip
// ----------------------------------------------------------------------------
module psd_front import psd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  psd_cfg_t   cfg,
  input  logic       in_valid,
  output logic       in_stall,
  input  psd_in_t    in_data,
  input  psd_qstat_t qstat,
  output logic       push,
  output psd_qitem_t push_item
);

  logic in_view;

  always_comb begin
    in_view = ($signed(in_data.pos_x) >= $signed(cfg.view_left))  &&
              ($signed(in_data.pos_x) <= $signed(cfg.view_right)) &&
              ($signed(in_data.pos_y) >= $signed(cfg.view_top))   &&
              ($signed(in_data.pos_y) <= $signed(cfg.view_bottom));
  end

  always_comb begin
    in_stall        = qstat.full;
    push            = in_valid && !qstat.full;
    push_item.pos_x = in_data.pos_x;
    push_item.pos_y = in_data.pos_y;
    if (in_data.cmd) begin
      push_item.op = OP_TICK;
    end else if (in_view) begin
      push_item.op = OP_MOVE;
    end else begin
      push_item.op = OP_SKIP;
    end
  end

  // a push never meets a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full)
    else $error("push into full queue");

  // a tick is always classified as such
  a_tick_class: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_data.cmd) |-> (push_item.op == OP_TICK))
    else $error("tick misclassified");

  // a move outside the view is skipped
  a_skip_class: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_data.cmd && !in_view) |-> (push_item.op == OP_SKIP))
    else $error("outside move not skipped");

endmodule

FILE: src/psd_queue.sv
// ----------------------------------------------------------------------------
// psd_queue
// short register queue between front and back
// ----------------------------------------------------------------------------
module psd_queue import psd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  psd_qitem_t push_item,
  input  logic       pop,
  output psd_qitem_t head_item,
  output psd_qstat_t qstat
);

  psd_qitem_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_comb begin
    head_item   = entries[rd_ptr];
    qstat.full  = (count == QCNT_W'(QUEUE_DEPTH));
    qstat.valid = (count != '0);
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> qstat.valid)
    else $error("pop from empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + QCNT_W'(1)))
    else $error("queue count lost a push");

endmodule

FILE: src/psd_back.sv
// ----------------------------------------------------------------------------
// psd_back
// carries out classified items: window update, u-turn test, timer, result
// ----------------------------------------------------------------------------
module psd_back import psd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  psd_cfg_t   cfg,
  input  psd_qstat_t qstat,
  input  psd_qitem_t head_item,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output psd_out_t   out_data
);

  logic signed [DELTA_W-1:0] win_x [WINDOW_DEPTH];
  logic signed [DELTA_W-1:0] win_y [WINDOW_DEPTH];
  logic [HEAD_W-1:0]         head;
  logic signed [SUM_W-1:0]   sum_x;
  logic signed [SUM_W-1:0]   sum_y;
  logic signed [SUM_W-1:0]   prev_sum_x;
  logic signed [SUM_W-1:0]   prev_sum_y;
  logic signed [15:0]        last_x;
  logic signed [15:0]        last_y;
  logic [7:0]                uturn_count;
  logic [15:0]               window_timer;
  logic                      timer_running;

  logic signed [DELTA_W-1:0] dx;
  logic signed [DELTA_W-1:0] dy;
  logic signed [SUM_W-1:0]   sum_x_next;
  logic signed [SUM_W-1:0]   sum_y_next;
  logic signed [PROD_W-1:0]  prod_x;
  logic signed [PROD_W-1:0]  prod_y;
  logic signed [DOT_W-1:0]   dot;
  logic                      is_uturn;
  logic [7:0]                count_inc;
  logic [7:0]                uturn_count_next;
  logic [15:0]               window_timer_next;
  logic                      timer_running_next;
  logic [HEAD_W-1:0]         head_next;
  logic                      do_move;
  psd_out_t                  result;

  assign pop     = qstat.valid && (!out_valid || !out_stall);
  assign do_move = pop && (head_item.op == OP_MOVE);

  always_comb begin
    dx = DELTA_W'($signed(head_item.pos_x)) - DELTA_W'(last_x);
    dy = DELTA_W'($signed(head_item.pos_y)) - DELTA_W'(last_y);
    sum_x_next = sum_x - SUM_W'(win_x[head]) + SUM_W'(dx);
    sum_y_next = sum_y - SUM_W'(win_y[head]) + SUM_W'(dy);
    prod_x = PROD_W'(sum_x_next) * PROD_W'(prev_sum_x);
    prod_y = PROD_W'(sum_y_next) * PROD_W'(prev_sum_y);
    dot    = DOT_W'(prod_x) + DOT_W'(prod_y);
    if (head == HEAD_W'(WINDOW_DEPTH - 1)) begin
      head_next = '0;
    end else begin
      head_next = head + HEAD_W'(1);
    end
    count_inc = (uturn_count == COUNT_MAX) ? uturn_count : uturn_count + 8'd1;
  end

  always_comb begin
    is_uturn           = 1'b0;
    uturn_count_next   = uturn_count;
    window_timer_next  = window_timer;
    timer_running_next = timer_running;
    result.uturn       = 1'b0;
    result.shake       = 1'b0;
    case (head_item.op)
      OP_TICK: begin
        if (timer_running) begin
          if (window_timer <= 16'd1) begin
            window_timer_next  = '0;
            timer_running_next = 1'b0;
            uturn_count_next   = '0;
          end else begin
            window_timer_next = window_timer - 16'd1;
          end
        end
      end
      OP_MOVE: begin
        is_uturn = dot[DOT_W-1];
        if (is_uturn) begin
          if (uturn_count == '0) begin
            window_timer_next  = cfg.time_window;
            timer_running_next = 1'b1;
          end
          uturn_count_next = count_inc;
          result.uturn     = 1'b1;
          result.shake     = (count_inc >= cfg.count_threshold);
        end
      end
      default: begin
      end
    endcase
    result.shake_count = uturn_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        win_x[i] <= '0;
        win_y[i] <= '0;
      end
      head          <= '0;
      sum_x         <= '0;
      sum_y         <= '0;
      prev_sum_x    <= '0;
      prev_sum_y    <= '0;
      last_x        <= '0;
      last_y        <= '0;
      uturn_count   <= '0;
      window_timer  <= '0;
      timer_running <= 1'b0;
    end else if (pop) begin
      uturn_count   <= uturn_count_next;
      window_timer  <= window_timer_next;
      timer_running <= timer_running_next;
      if (do_move) begin
        win_x[head] <= dx;
        win_y[head] <= dy;
        head        <= head_next;
        sum_x       <= sum_x_next;
        sum_y       <= sum_y_next;
        prev_sum_x  <= sum_x_next;
        prev_sum_y  <= sum_y_next;
        last_x      <= $signed(head_item.pos_x);
        last_y      <= $signed(head_item.pos_y);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= result;
    end
  end

  a_count_timer: assert property (@(posedge clk) disable iff (rst)
    (uturn_count != '0) |-> timer_running)
    else $error("count held with timer stopped");

  a_shake_uturn: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.shake || out_data.uturn))
    else $error("shake without u-turn");

  a_sum_prev: assert property (@(posedge clk) disable iff (rst)
    (sum_x == prev_sum_x) && (sum_y == prev_sum_y))
    else $error("window sum and previous sum diverged");

endmodule

FILE: src/pointer_shake_detector_core.sv
// ----------------------------------------------------------------------------
// pointer_shake_detector_core
// pointer shake detector with register port, front classifier and back unit
// ----------------------------------------------------------------------------
// the block takes one item per clock while the input does not stall and
// returns one result per item, in order. an accepted item sits in a two-item
// queue, is carried out by the back unit when it is popped and lands in the
// output register, which holds the result until the output side takes it.
// while the output side holds off, two more items fill the queue and then the
// input stalls. the sustained rate of one item per cycle while the output
// side does not stall is set by the back unit, which updates the delta
// window, both running sums and the dot-product u-turn test at each pop.
// moves outside the inclusive view rectangle return a result with uturn and
// shake low and leave all state alone; ticks only run the countdown that
// clears the u-turn count. registers sit at byte address 4*i and must be
// written only while the block is idle.
module pointer_shake_detector_core import psd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // input items
  input  logic              in_valid,
  output logic              in_stall,
  input  psd_in_t           in_data,
  // result items
  output logic              out_valid,
  input  logic              out_stall,
  output psd_out_t          out_data
);

  psd_cfg_t             cfg;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;
  logic                 push;
  logic                 pop;
  psd_qitem_t           push_item;
  psd_qitem_t           head_item;
  psd_qstat_t           qstat;

  // register file, word addressed
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.view_left       <= 16'd0;
      cfg.view_top        <= 16'd0;
      cfg.view_right      <= 16'd32767;
      cfg.view_bottom     <= 16'd32767;
      cfg.count_threshold <= 8'd4;
      cfg.time_window     <= 16'd1000;
    end else if (wr_en) begin
      case (reg_idx)
        REG_VIEW_LEFT:       cfg.view_left       <= pwdata[15:0];
        REG_VIEW_TOP:        cfg.view_top        <= pwdata[15:0];
        REG_VIEW_RIGHT:      cfg.view_right      <= pwdata[15:0];
        REG_VIEW_BOTTOM:     cfg.view_bottom     <= pwdata[15:0];
        REG_COUNT_THRESHOLD: cfg.count_threshold <= pwdata[7:0];
        REG_TIME_WINDOW:     cfg.time_window     <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // read back, view edges sign extended
  always_comb begin
    case (reg_idx)
      REG_VIEW_LEFT:       prdata = DATA_W'($signed(cfg.view_left));
      REG_VIEW_TOP:        prdata = DATA_W'($signed(cfg.view_top));
      REG_VIEW_RIGHT:      prdata = DATA_W'($signed(cfg.view_right));
      REG_VIEW_BOTTOM:     prdata = DATA_W'($signed(cfg.view_bottom));
      REG_COUNT_THRESHOLD: prdata = DATA_W'(cfg.count_threshold);
      REG_TIME_WINDOW:     prdata = DATA_W'(cfg.time_window);
      default:             prdata = '0;
    endcase
  end

  // front: accept and classify
  psd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .qstat     (qstat),
    .push      (push),
    .push_item (push_item)
  );

  // queue decouples the two halves
  psd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .qstat     (qstat)
  );

  // back: state update and result register
  psd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .qstat     (qstat),
    .head_item (head_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: bench/psd_checker.sv
// ----------------------------------------------------------------------------
// psd_checker
// watches the register port and both item channels of the shake detector,
// predicts every result and compares it with what the block returns
// ----------------------------------------------------------------------------
module psd_checker import psd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              pready,
  input  logic              in_valid,
  input  logic              in_stall,
  input  psd_in_t           in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  psd_out_t          out_data,
  output int                fails,
  output int                pending,
  output int                n_uturn,
  output int                n_shake,
  output int                top_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic CMD_TICK = 1'(OP_TICK);

  // register copy
  logic signed [15:0] view_l, view_t, view_r, view_b;
  logic [7:0]         thresh;
  logic [15:0]        span;

  // tracker state
  logic signed [DELTA_W-1:0] win_x [WINDOW_DEPTH];
  logic signed [DELTA_W-1:0] win_y [WINDOW_DEPTH];
  logic [HEAD_W-1:0]         head;
  logic signed [SUM_W-1:0]   sum_x, sum_y, old_x, old_y;
  logic signed [15:0]        last_px, last_py;
  logic [7:0]                turns;
  logic [15:0]               ticks_left;
  logic                      timer_on;

  psd_out_t shake_results_due [$];
  int       miss;
  int       uturns_seen, shakes_seen, count_peak;

  function automatic psd_out_t next_shake_result(psd_in_t it);
    psd_out_t                  r;
    logic signed [15:0]        px, py;
    logic signed [DELTA_W-1:0] dx, dy;
    logic signed [DOT_W-1:0]   dot;
    r  = '0;
    px = it.pos_x;
    py = it.pos_y;
    if (it.cmd == CMD_TICK) begin
      if (timer_on) begin
        if (ticks_left <= 16'd1) begin
          ticks_left = '0;
          timer_on   = 1'b0;
          turns      = '0;
        end else begin
          ticks_left = ticks_left - 16'd1;
        end
      end
    end else if (px >= view_l && px <= view_r && py >= view_t && py <= view_b) begin
      dx = px - last_px;
      dy = py - last_py;
      sum_x = sum_x - win_x[head] + dx;
      sum_y = sum_y - win_y[head] + dy;
      win_x[head] = dx;
      win_y[head] = dy;
      head = head + 1'b1;
      dot = sum_x * old_x + sum_y * old_y;
      if (dot < 0) begin
        r.uturn = 1'b1;
        if (turns == '0) begin
          ticks_left = span;
          timer_on   = 1'b1;
        end
        if (turns != COUNT_MAX) turns = turns + 8'd1;
        if (turns >= thresh) r.shake = 1'b1;
      end
      old_x   = sum_x;
      old_y   = sum_y;
      last_px = px;
      last_py = py;
    end
    r.shake_count = turns;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    psd_out_t want;
    if (rst) begin
      view_l = '0;
      view_t = '0;
      view_r = 16'sd32767;
      view_b = 16'sd32767;
      thresh = 8'd4;
      span   = 16'd1000;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        win_x[i] = '0;
        win_y[i] = '0;
      end
      head       = '0;
      sum_x      = '0;
      sum_y      = '0;
      old_x      = '0;
      old_y      = '0;
      last_px    = '0;
      last_py    = '0;
      turns      = '0;
      ticks_left = '0;
      timer_on   = 1'b0;
      shake_results_due.delete();
    end else begin
      // results first, so an item taken at the same edge cannot be matched
      if (out_valid && !out_stall) begin
        if (out_data.uturn) uturns_seen++;
        if (out_data.shake) shakes_seen++;
        if (int'(out_data.shake_count) > count_peak)
          count_peak = int'(out_data.shake_count);
        if (shake_results_due.size() == 0) begin
          miss++;
          if (miss <= 10)
            $display("%0t: unexpected result uturn %0b shake %0b count %0d", $time,
                     out_data.uturn, out_data.shake, out_data.shake_count);
        end else begin
          want = shake_results_due.pop_front();
          if (out_data.uturn !== want.uturn || out_data.shake !== want.shake ||
              out_data.shake_count !== want.shake_count) begin
            miss++;
            if (miss <= 10)
              $display({"%0t: mismatch, expected uturn %0b shake %0b count %0d,",
                        " got uturn %0b shake %0b count %0d"},
                       $time, want.uturn, want.shake, want.shake_count,
                       out_data.uturn, out_data.shake, out_data.shake_count);
          end
        end
      end
      if (in_valid && !in_stall)
        shake_results_due.push_back(next_shake_result(in_data));
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1 -: REG_IDX_W])
          REG_VIEW_LEFT:       view_l = pwdata[15:0];
          REG_VIEW_TOP:        view_t = pwdata[15:0];
          REG_VIEW_RIGHT:      view_r = pwdata[15:0];
          REG_VIEW_BOTTOM:     view_b = pwdata[15:0];
          REG_COUNT_THRESHOLD: thresh = pwdata[7:0];
          REG_TIME_WINDOW:     span   = pwdata[15:0];
          default: ;
        endcase
      end
    end
    fails     <= miss;
    pending   <= shake_results_due.size();
    n_uturn   <= uturns_seen;
    n_shake   <= shakes_seen;
    top_count <= count_peak;
  end

endmodule

FILE: bench/pointer_shake_detector_core_tb.sv
// ----------------------------------------------------------------------------
// pointer_shake_detector_core_tb
// drives pointer moves and ticks through the shake detector under several
// register settings, with random gaps and output stalls, and gives the verdict
// ----------------------------------------------------------------------------
module pointer_shake_detector_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import psd_pkg::*;

  localparam logic CMD_MOVE = 1'(OP_MOVE);
  localparam logic CMD_TICK = 1'(OP_TICK);

  // receiver behaviour, one mode per stretch of cycles
  typedef enum logic [2:0] {
    RX_FREE,
    RX_RANDOM,
    RX_PERIODIC,
    RX_ARM,
    RX_HOLD
  } rx_mode_t;

  logic              clk     = 1'b0;
  logic              rst     = 1'b1;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_stall;
  psd_in_t           in_data  = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  psd_out_t          out_data;

  int fails, pending, n_uturn, n_shake, top_count;

  // sender bookkeeping
  int n_sent, n_moves, n_ticks, n_settings;
  int burst_left = 1;
  int cur_tick_pct;
  // range that generated positions are drawn from (the view, or all of it)
  int gl, gt, gr, gb;

  always #5 clk = ~clk;

  pointer_shake_detector_core dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  psd_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .fails     (fails),
    .pending   (pending),
    .n_uturn   (n_uturn),
    .n_shake   (n_shake),
    .top_count (top_count)
  );

  // ---------------------------------------------------------------- helpers

  function automatic int pick(int lo, int hi);
    if (hi <= lo) return lo;
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int clampi(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic psd_in_t move_item(int x, int y);
    psd_in_t it;
    it.cmd   = CMD_MOVE;
    it.pos_x = 16'(x);
    it.pos_y = 16'(y);
    return it;
  endfunction

  // position bits of a tick are don't-care, so they get random junk
  function automatic psd_in_t tick_item();
    psd_in_t it;
    it.cmd   = CMD_TICK;
    it.pos_x = 16'($urandom);
    it.pos_y = 16'($urandom);
    return it;
  endfunction

  // offer one item and hold it until taken; bursts end in a random gap
  task automatic push_item(psd_in_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    n_sent++;
    if (it.cmd == CMD_TICK) n_ticks++;
    else n_moves++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // a move of a shape, now and then preceded by a tick
  task automatic shape_move(int x, int y);
    if ($urandom_range(99) < cur_tick_pct) push_item(tick_item());
    push_item(move_item(x, y));
  endtask

  // stop offering and wait until every predicted result has come back;
  // pending is a registered copy, hence the first clock before looking at it
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // setup then access phase; psel drops after each write so writes never overlap
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // mixed traffic: mostly shapes that produce u-turns, some noise and ticks;
  // half way through the sender waits for the block to empty
  task automatic run_traffic(int n, bit long_tri);
    int stop, kind, len, k, cx, cy, rad, v, dir, flip, x, y;
    int tx [3];
    int ty [3];
    bit drained;
    stop    = n_sent + n;
    drained = 1'b0;
    while (n_sent < stop) begin
      if (!drained && n_sent >= stop - n / 2) begin
        drain_results();
        drained = 1'b1;
      end
      kind = $urandom_range(9);
      if (kind <= 4) begin
        // three points with acute corners: once the window is full every
        // move turns the window sum by more than a right angle
        len = long_tri ? $urandom_range(60, 300) : $urandom_range(6, 40);
        rad = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 4000);
        cx  = pick(gl, gr);
        cy  = pick(gt, gb);
        tx[0] = cx;       ty[0] = cy - rad;
        tx[1] = cx - rad; ty[1] = cy + rad;
        tx[2] = cx + rad; ty[2] = cy + rad;
        v   = $urandom_range(2);
        dir = $urandom_range(1) ? 1 : 2;
        for (k = 0; k < len && n_sent < stop; k++) begin
          shape_move(clampi(tx[v], gl, gr), clampi(ty[v], gt, gb));
          v = (v + dir) % 3;
        end
      end else if (kind <= 7) begin
        // back-and-forth sweep with uneven steps and a little vertical wobble
        len  = $urandom_range(8, 40);
        x    = pick(gl, gr);
        y    = pick(gt, gb);
        dir  = 1;
        flip = $urandom_range(2, 9);
        for (k = 0; k < len && n_sent < stop; k++) begin
          x = clampi(x + dir * int'($urandom_range(1, 1500)), gl, gr);
          y = clampi(y + int'($urandom_range(200)) - 100, gt, gb);
          shape_move(x, y);
          flip--;
          if (flip == 0) begin
            dir  = -dir;
            flip = $urandom_range(2, 9);
          end
        end
      end else if (kind == 8) begin
        // noise: anywhere, on and just past the view edges, stray ticks
        len = $urandom_range(1, 8);
        for (k = 0; k < len && n_sent < stop; k++) begin
          case ($urandom_range(2))
            0: push_item(move_item($urandom, $urandom));
            1: begin
              case ($urandom_range(3))
                0: x = gl;
                1: x = gr;
                2: x = gl - 1;
                default: x = gr + 1;
              endcase
              case ($urandom_range(3))
                0: y = gt;
                1: y = gb;
                2: y = gt - 1;
                default: y = gb + 1;
              endcase
              push_item(move_item(x, y));
            end
            default: push_item(tick_item());
          endcase
        end
      end else begin
        // run of ticks to let the countdown expire
        len = $urandom_range(1, 15);
        for (k = 0; k < len && n_sent < stop; k++) push_item(tick_item());
      end
    end
  endtask

  // new register setting, written only once the block has gone idle
  task automatic run_phase(int l, int t, int r, int b, int thr, int win, int n,
                           int tick_pct, bit long_tri);
    drain_results();
    write_reg(REG_VIEW_LEFT,       DATA_W'(l));
    write_reg(REG_VIEW_TOP,        DATA_W'(t));
    write_reg(REG_VIEW_RIGHT,      DATA_W'(r));
    write_reg(REG_VIEW_BOTTOM,     DATA_W'(b));
    write_reg(REG_COUNT_THRESHOLD, DATA_W'(thr));
    write_reg(REG_TIME_WINDOW,     DATA_W'(win));
    // an empty view still gets moves, drawn from the whole plane
    if (l <= r) begin gl = l; gr = r; end
    else begin gl = -32768; gr = 32767; end
    if (t <= b) begin gt = t; gb = b; end
    else begin gt = -32768; gb = 32767; end
    cur_tick_pct = tick_pct;
    n_settings++;
    run_traffic(n, long_tri);
  endtask

  // ---------------------------------------------------------------- receiver

  // stall pattern changes every stretch; every ninth stretch waits for the
  // sender to offer and then holds off long enough to back the block up
  initial begin : receiver
    rx_mode_t mode;
    int       left, pct, period, seg;
    logic     s;
    mode = RX_FREE;
    left = 0;
    pct  = 0;
    period = 2;
    seg  = 0;
    do @(posedge clk); while (rst);
    forever begin
      @(posedge clk);
      if (mode == RX_ARM) begin
        if (in_valid) begin
          mode = RX_HOLD;
          left = $urandom_range(150, 300);
        end
      end else if (left <= 0) begin
        seg++;
        if (seg % 9 == 4) begin
          mode = RX_ARM;
        end else begin
          case ($urandom_range(2))
            0: mode = RX_FREE;
            1: begin
              mode = RX_RANDOM;
              pct  = $urandom_range(10, 80);
            end
            default: begin
              mode   = RX_PERIODIC;
              period = $urandom_range(2, 7);
            end
          endcase
        end
        left = $urandom_range(20, 200);
      end
      case (mode)
        RX_RANDOM:   s = ($urandom_range(99) < pct);
        RX_PERIODIC: s = ((left % period) == 0);
        RX_HOLD:     s = 1'b1;
        default:     s = 1'b0;
      endcase
      out_stall <= s;
      if (mode != RX_ARM) left--;
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    psd_in_t it;
    int      l, t, r, b, k;
    int      dtx [3];
    int      dty [3];
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part under reset settings (view 0..32767, threshold 4)
    gl = 0; gt = 0; gr = 32767; gb = 32767;
    it = tick_item();
    it.pos_x = '1;
    it.pos_y = '1;
    push_item(it);                     // tick with the countdown stopped
    push_item(move_item(0, 0));        // inclusive corner, zero delta
    push_item(move_item(32767, 32767));
    push_item(move_item(-1, 100));     // just left of the view
    push_item(move_item(100, -1));     // just above the view
    push_item(move_item(-32768, -32768));
    push_item(move_item(32767, 0));
    // a small triangle: u-turns on moves 7 and 9 to 12, shake once four are in
    dtx[0] = 1000; dty[0] = 700;
    dtx[1] = 700;  dty[1] = 1300;
    dtx[2] = 1300; dty[2] = 1300;
    for (k = 0; k < 12; k++) push_item(move_item(dtx[k % 3], dty[k % 3]));
    repeat (3) push_item(tick_item());

    // whole plane as view, short countdown
    run_phase(-32768, -32768, 32767, 32767, 4, 300, 150, 10, 1'b0);
    // highest threshold and longest countdown: the count runs up to its cap
    run_phase(-32768, -32768, 32767, 32767, 255, 65535, 350, 2, 1'b1);
    // random view, every u-turn a shake, countdown of one tick
    l = pick(-32768, 32767); r = pick(l, 32767);
    t = pick(-32768, 32767); b = pick(t, 32767);
    run_phase(l, t, r, b, 1, 1, 120, 15, 1'b0);
    // zero threshold and zero countdown
    l = pick(-32768, 32767); r = pick(l, 32767);
    t = pick(-32768, 32767); b = pick(t, 32767);
    run_phase(l, t, r, b, 0, 0, 100, 15, 1'b0);
    // empty view: left beyond right and top beyond bottom
    run_phase(200, 50, -200, -50, 3, 20, 60, 10, 1'b0);
    // random view, moderate threshold and countdown
    l = pick(-32768, 32767); r = pick(l, 32767);
    t = pick(-32768, 32767); b = pick(t, 32767);
    run_phase(l, t, r, b, pick(2, 10), pick(5, 60), 200, 20, 1'b0);
    // a view of a single point
    l = pick(-32768, 32767);
    t = pick(-32768, 32767);
    run_phase(l, t, l, t, 1, 10, 60, 10, 1'b0);
    // back to the reset view
    run_phase(0, 0, 32767, 32767, 4, 1000, 150, 10, 1'b0);

    drain_results();
    repeat (10) @(posedge clk);
    $display("run covered %0d items (%0d moves, %0d ticks) over %0d register settings",
             n_sent, n_moves, n_ticks, n_settings + 1);
    $display("results seen: %0d u-turns, %0d shakes, highest count %0d",
             n_uturn, n_shake, top_count);
    if (fails == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // a hung handshake ends the run here
  initial begin : watchdog
    #(2_000_000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
